[rtl/sfr_pkg.sv]
package sfr_pkg;

  localparam int unsigned MaxPattern     = 16;
  localparam int unsigned MaxReplacement = 16;
  localparam int unsigned RegIdxW        = 3;
  localparam int unsigned CfgDataW       = 64;
  localparam int unsigned LenW           = 5;

  typedef enum logic [RegIdxW-1:0] {
    RegPatLo = 3'd0,
    RegPatHi = 3'd1,
    RegPatLen = 3'd2,
    RegRepLo = 3'd3,
    RegRepHi = 3'd4,
    RegRepLen = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       byte_valid;
    logic       last_of_text;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StShift = 4'b0010,
    StEmit  = 4'b0100,
    StFlush = 4'b1000
  } state_e;

endpackage

[rtl/sfr_stream_if.sv]
interface sfr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/stream_find_and_replace.sv]
// channel | role   | fields
// in_if   | sink   | text_byte, byte_present, end_of_text
// out_if  | source | result_byte, byte_valid, last_of_text
// cfg     | write  | cfg_we_i, cfg_idx_i, cfg_data_i
// pass-through or a growing match is done in idle; a full match emits the replacement bytes
// a mismatch loads the cell row and, while the output is free, shifts it one place per cycle
// emitting the front byte, until the rest is a pattern prefix
// end of text flushes the held bytes in StFlush; a bare end with none held gives an empty marker
// async active-low reset clears config, held length and the output register
// input is taken only when idle with the output register free; a stalled output freezes it
module stream_find_and_replace #(
  parameter int unsigned MAX_PATTERN     = sfr_pkg::MaxPattern,
  parameter int unsigned MAX_REPLACEMENT = sfr_pkg::MaxReplacement
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfr_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  logic [sfr_pkg::CfgDataW-1:0] cfg_data_i,
  sfr_stream_if.sink                   in_if,
  sfr_stream_if.source                 out_if
);
  import sfr_pkg::*;

  localparam int unsigned N = MAX_PATTERN;

  logic [63:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic [LenW-1:0] pat_len_q, rep_len_q, m_q, m_d;
  logic [LenW-1:0] pl, rl, m0, win_q, win_d, cnt_q, cnt_d;
  logic end_q, end_d;
  state_e st_q, st_d;
  out_item_t ob_q, ob_d;
  logic ov_q, ov_d;

  logic [7:0] pbyte [16];
  logic [7:0] rbyte [16];
  logic [7:0] cbyte [N];
  logic [N:0] chain;
  logic load, shift;
  logic [7:0] c_in;
  logic win_ok, slot, in_acc, pat_len_wr;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pbyte[i]   = pat_lo_q[8*i +: 8];
      pbyte[i+8] = pat_hi_q[8*i +: 8];
      rbyte[i]   = rep_lo_q[8*i +: 8];
      rbyte[i+8] = rep_hi_q[8*i +: 8];
    end
  end

  assign pl = (pat_len_q > LenW'(MAX_PATTERN)) ? LenW'(MAX_PATTERN) : pat_len_q;
  assign rl = (rep_len_q > LenW'(MAX_REPLACEMENT)) ? LenW'(MAX_REPLACEMENT) : rep_len_q;
  assign m0 = (pl == '0 || m_q >= pl) ? '0 : m_q;

  assign chain[0] = 1'b1;
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic [7:0] nb;
      if (g == N - 1) begin : g_last
        assign nb = 8'd0;
      end else begin : g_mid
        assign nb = cbyte[g+1];
      end
      sfr_cell u_cell (
        .clk_i,
        .rst_ni,
        .load_i      (load && (LenW'(g) <= m0)),
        .load_byte_i ((LenW'(g) < m0) ? pbyte[g] : c_in),
        .shift_i     (shift),
        .nbr_byte_i  (nb),
        .pat_byte_i  (pbyte[g]),
        .care_i      (LenW'(g) < win_q),
        .prev_match_i(chain[g]),
        .byte_o      (cbyte[g]),
        .match_o     (chain[g+1])
      );
    end
  endgenerate

  assign win_ok = chain[N];

  assign slot = !ov_q || out_if.ready;
  assign c_in = in_if.data.text_byte;
  assign in_if.ready = (st_q == StIdle) && slot && !cfg_we_i;
  assign in_acc = in_if.valid && in_if.ready;
  assign pat_len_wr = cfg_we_i && (reg_idx_e'(cfg_idx_i) == RegPatLen);

  always_comb begin
    st_d  = st_q;
    m_d   = m_q;
    win_d = win_q;
    cnt_d = cnt_q;
    end_d = end_q;
    ov_d  = ov_q && !out_if.ready;
    ob_d  = ob_q;
    load  = 1'b0;
    shift = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_acc) begin
          end_d = in_if.data.end_of_text;
          cnt_d = '0;
          m_d   = m0;
          if (!in_if.data.byte_present) begin
            if (in_if.data.end_of_text) begin
              if (m0 != '0) begin
                st_d = StFlush;
              end else begin
                ov_d = 1'b1;
                ob_d = '{8'd0, 1'b0, 1'b1};
              end
            end
          end else if (pl == '0) begin
            ov_d = 1'b1;
            ob_d = '{c_in, 1'b1, in_if.data.end_of_text};
          end else if (c_in == pbyte[m0[3:0]]) begin
            if (m0 + LenW'(1) == pl) begin
              m_d = '0;
              if (rl != '0) begin
                st_d = StEmit;
              end else if (in_if.data.end_of_text) begin
                ov_d = 1'b1;
                ob_d = '{8'd0, 1'b0, 1'b1};
              end
            end else begin
              m_d = m0 + LenW'(1);
              if (in_if.data.end_of_text) st_d = StFlush;
            end
          end else begin
            load  = 1'b1;
            win_d = m0 + LenW'(1);
            st_d  = StShift;
          end
        end
      end
      StShift: begin
        if (win_ok) begin
          m_d  = win_q;
          st_d = (end_q && win_q != '0) ? StFlush : StIdle;
        end else if (slot) begin
          ov_d  = 1'b1;
          ob_d  = '{cbyte[0], 1'b1, end_q && (win_q == LenW'(1))};
          shift = 1'b1;
          win_d = win_q - LenW'(1);
        end
      end
      StEmit: begin
        if (slot) begin
          ov_d  = 1'b1;
          ob_d  = '{rbyte[cnt_q[3:0]], 1'b1, end_q && (cnt_q + LenW'(1) == rl)};
          cnt_d = cnt_q + LenW'(1);
          if (cnt_q + LenW'(1) == rl) st_d = StIdle;
        end
      end
      StFlush: begin
        if (slot) begin
          ov_d  = 1'b1;
          ob_d  = '{pbyte[cnt_q[3:0]], 1'b1, cnt_q + LenW'(1) == m_q};
          cnt_d = cnt_q + LenW'(1);
          if (cnt_q + LenW'(1) == m_q) begin
            st_d = StIdle;
            m_d  = '0;
          end
        end
      end
      default: st_d = StIdle;
    endcase
    if (pat_len_wr) m_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; m_q <= '0; win_q <= '0; cnt_q <= '0; end_q <= 1'b0;
      ov_q <= 1'b0; ob_q <= '0;
      pat_lo_q <= '0; pat_hi_q <= '0; rep_lo_q <= '0; rep_hi_q <= '0;
      pat_len_q <= '0; rep_len_q <= '0;
    end else begin
      st_q <= st_d; m_q <= m_d; win_q <= win_d; cnt_q <= cnt_d; end_q <= end_d;
      ov_q <= ov_d; ob_q <= ob_d;
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          RegPatLo:  pat_lo_q <= cfg_data_i;
          RegPatHi:  pat_hi_q <= cfg_data_i;
          RegPatLen: pat_len_q <= cfg_data_i[LenW-1:0];
          RegRepLo:  rep_lo_q <= cfg_data_i;
          RegRepHi:  rep_hi_q <= cfg_data_i;
          RegRepLen: rep_len_q <= cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_if.valid = ov_q;
  assign out_if.data  = ob_q;

  a_held_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIdle && pl != '0) |-> (m_q < pl))
    else $error("held length not below pattern length");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (st_q == StIdle))
    else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_if.ready) |=> ov_q)
    else $error("output dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_if.ready) |=> $stable(ob_q))
    else $error("output changed while stalled");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q))
    else $error("state not one-hot");
endmodule

[rtl/sfr_cell.sv]
module sfr_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic [7:0] load_byte_i,
  input  logic       shift_i,
  input  logic [7:0] nbr_byte_i,
  input  logic [7:0] pat_byte_i,
  input  logic       care_i,
  input  logic       prev_match_i,
  output logic [7:0] byte_o,
  output logic       match_o
);
  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (load_i) begin
      byte_d = load_byte_i;
    end else if (shift_i) begin
      byte_d = nbr_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // cells past the window end always agree
  assign byte_o  = byte_q;
  assign match_o = prev_match_i & (!care_i | (byte_q == pat_byte_i));
endmodule

[bench/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  localparam int unsigned NumRandom = 420;

  typedef struct {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;
    logic       has_expect;
    logic [7:0] exp_byte;
    logic       exp_valid;
    logic       exp_last;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  sfr_stream_if #(.T(in_item_t)) in_if ();
  sfr_stream_if #(.T(out_item_t)) out_if ();

  stream_find_and_replace u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // shadow copy of the configuration and the match state
  logic [63:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic [4:0]  pat_len_q, rep_len_q;
  int unsigned held_len;
  out_item_t   edited_text_q[$];
  int unsigned fail_count = 0;
  bit          idle_enable = 1'b1;
  bit          hold_off = 1'b0;

  function automatic logic [7:0] pat_byte(int unsigned i);
    return (i < 8) ? pat_lo_q[8*i +: 8] : pat_hi_q[8*(i-8) +: 8];
  endfunction

  function automatic logic [7:0] rep_byte(int unsigned i);
    return (i < 8) ? rep_lo_q[8*i +: 8] : rep_hi_q[8*(i-8) +: 8];
  endfunction

  function automatic logic [7:0] window_byte(int unsigned j, int unsigned m, logic [7:0] c);
    return (j < m) ? pat_byte(j) : c;
  endfunction

  task automatic push_byte(logic [7:0] b, logic v);
    out_item_t o;
    o.result_byte = b;
    o.byte_valid = v;
    o.last_of_text = 1'b0;
    edited_text_q.push_back(o);
  endtask

  task automatic predict_replace(in_item_t it);
    int unsigned plen, rlen, m, keep, n0;
    bit ok;
    plen = (pat_len_q > MaxPattern) ? MaxPattern : pat_len_q;
    rlen = (rep_len_q > MaxReplacement) ? MaxReplacement : rep_len_q;
    m = held_len;
    n0 = edited_text_q.size();
    if (plen == 0 || m >= plen) m = 0;
    if (it.byte_present) begin
      if (plen == 0) begin
        push_byte(it.text_byte, 1'b1);
      end else if (it.text_byte == pat_byte(m)) begin
        m++;
        if (m == plen) begin
          for (int j = 0; j < rlen; j++) push_byte(rep_byte(j), 1'b1);
          m = 0;
        end
      end else begin
        keep = 0;
        for (int k = m; k > 0; k--) begin
          ok = 1'b1;
          for (int j = 0; j < k; j++)
            if (window_byte(m + 1 - k + j, m, it.text_byte) != pat_byte(j)) ok = 1'b0;
          if (ok) begin
            keep = k;
            break;
          end
        end
        for (int j = 0; j < m + 1 - keep; j++) push_byte(window_byte(j, m, it.text_byte), 1'b1);
        m = keep;
      end
    end
    if (it.end_of_text) begin
      for (int j = 0; j < m; j++) push_byte(pat_byte(j), 1'b1);
      m = 0;
      if (edited_text_q.size() == n0) push_byte(8'd0, 1'b0);
      edited_text_q[$].last_of_text = 1'b1;
    end
    held_len = m;
  endtask

  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegPatLo:  pat_lo_q = val;
      RegPatHi:  pat_hi_q = val;
      RegPatLen: begin
        pat_len_q = val[4:0];
        held_len = 0;
      end
      RegRepLo:  rep_lo_q = val;
      RegRepHi:  rep_hi_q = val;
      RegRepLen: rep_len_q = val[4:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (edited_text_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic configure(logic [63:0] plo, logic [63:0] phi, logic [4:0] plen,
                           logic [63:0] rlo, logic [63:0] rhi, logic [4:0] rlen);
    wait_drained();
    write_reg(RegPatLo, plo);
    write_reg(RegPatHi, phi);
    write_reg(RegPatLen, {59'd0, plen});
    write_reg(RegRepLo, rlo);
    write_reg(RegRepHi, rhi);
    write_reg(RegRepLen, {59'd0, rlen});
  endtask

  // a typed expectation stands in for the predicted single result
  task automatic send_text(in_item_t it, bit has_exp = 1'b0, out_item_t exp_item = '0);
    @(negedge clk_i);
    while (idle_enable && $urandom_range(99) < 13) @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data <= it;
    predict_replace(it);
    if (has_exp) edited_text_q[$] = exp_item;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    out_if.ready <= !hold_off && !(idle_enable && $urandom_range(99) < 13);
  end

  always @(posedge clk_i) begin
    out_item_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (edited_text_q.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, got);
        fail_count++;
      end else begin
        want = edited_text_q.pop_front();
        if (got.result_byte !== want.result_byte || got.byte_valid !== want.byte_valid ||
            got.last_of_text !== want.last_of_text) begin
          $display({"%0t: mismatch expected byte=%h valid=%b last=%b ",
                    "actual byte=%h valid=%b last=%b"},
                   $time, want.result_byte, want.byte_valid, want.last_of_text,
                   got.result_byte, got.byte_valid, got.last_of_text);
          fail_count++;
        end
      end
    end
  end

  function automatic in_item_t mk(logic [7:0] b, logic p, logic e);
    in_item_t it;
    it.text_byte = b;
    it.byte_present = p;
    it.end_of_text = e;
    return it;
  endfunction

  initial begin
    stim_row_t table_rows[$];
    out_item_t row_exp;
    in_item_t it;
    int unsigned plen, sent, mode;
    logic [63:0] plo, phi;

    pat_lo_q = '0; pat_hi_q = '0; rep_lo_q = '0; rep_hi_q = '0;
    pat_len_q = '0; rep_len_q = '0; held_len = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // after reset: pass-through, bare end gives an empty marker
    table_rows = '{
      '{8'h00, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
      '{8'hff, 1'b1, 1'b0, 1'b1, 8'hff, 1'b1, 1'b0},
      '{8'h5a, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
      '{8'ha5, 1'b1, 1'b1, 1'b1, 8'ha5, 1'b1, 1'b1}
    };
    foreach (table_rows[i]) begin
      row_exp.result_byte = table_rows[i].exp_byte;
      row_exp.byte_valid = table_rows[i].exp_valid;
      row_exp.last_of_text = table_rows[i].exp_last;
      send_text(mk(table_rows[i].text_byte, table_rows[i].byte_present,
                   table_rows[i].end_of_text), table_rows[i].has_expect, row_exp);
    end

    // pattern "aab", replacement "XY"
    configure(64'h626161, 64'd0, 5'd3, 64'h5958, 64'd0, 5'd2);
    send_text(mk("a", 1'b1, 1'b0)); send_text(mk("a", 1'b1, 1'b0));
    send_text(mk("a", 1'b1, 1'b0)); send_text(mk("b", 1'b1, 1'b0));
    send_text(mk("a", 1'b1, 1'b0)); send_text(mk("a", 1'b1, 1'b0));
    send_text(mk("c", 1'b1, 1'b0)); send_text(mk("a", 1'b1, 1'b0));
    send_text(mk("a", 1'b0, 1'b1));
    // pattern length rewritten mid-text drops held bytes
    send_text(mk("a", 1'b1, 1'b0));
    configure(64'h626161, 64'd0, 5'd3, 64'h5958, 64'd0, 5'd0);
    send_text(mk("a", 1'b1, 1'b0)); send_text(mk("a", 1'b1, 1'b0));
    send_text(mk("b", 1'b1, 1'b1));
    // full-length pattern and oversized lengths saturate
    configure('1, '1, 5'd31, '1, 64'h0123456789abcdef, 5'd31);
    for (int i = 0; i < 17; i++) send_text(mk(8'hff, 1'b1, i == 16));
    send_text(mk(8'hff, 1'b1, 1'b0)); send_text(mk(8'h00, 1'b1, 1'b0));
    send_text(mk(8'hff, 1'b1, 1'b0)); send_text(mk(8'h00, 1'b0, 1'b1));

    // random part: small alphabet so matches are frequent
    sent = 0;
    while (sent < NumRandom) begin
      plen = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(4, 1);
      plo = {$urandom, $urandom};
      phi = {$urandom, $urandom};
      if ($urandom_range(3) != 0) begin
        plo = plo & 64'h0101010101010101 | 64'h6060606060606060;
        phi = phi & 64'h0101010101010101 | 64'h6060606060606060;
      end
      configure(plo, phi, plen[4:0], {$urandom, $urandom}, {$urandom, $urandom},
                5'($urandom_range(31) > 20 ? $urandom_range(31) : $urandom_range(3)));
      idle_enable = (sent < 120 || sent > 240);
      for (int n = 0; n < 60; n++) begin
        mode = $urandom_range(99);
        if (mode < 10) it = mk(8'($urandom), 1'($urandom), 1'($urandom));
        else if (mode < 75) it = mk(8'h60 | 8'($urandom_range(1)), 1'b1, 1'b0);
        else it = mk(pat_byte($urandom_range(plen > 16 ? 15 : (plen == 0 ? 0 : plen - 1))),
                     1'b1, 1'b0);
        if (n == 59) it.end_of_text = 1'b1;
        if (n == 20 && sent == 80) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (300) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        send_text(it);
        sent++;
      end
    end

    begin
      int unsigned guard;
      guard = 0;
      while (edited_text_q.size() != 0 && guard < 100000) begin
        @(posedge clk_i);
        guard++;
      end
      if (edited_text_q.size() != 0) fail_count++;
    end
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
